@@ rtl/core/dsb_pkg.sv @@
// Package of the supermer builder: shared types, register indices and constants.
// Used by every module of the block; depends on nothing.
package dsb_pkg;

   localparam logic [1:0] REG_K_LEN            = 2'd0;
   localparam logic [1:0] REG_M_LEN            = 2'd1;
   localparam logic [1:0] REG_NUM_DESTINATIONS = 2'd2;

   localparam logic [4:0]  K_LEN_RESET = 5'd17;
   localparam logic [4:0]  M_LEN_RESET = 5'd7;
   localparam logic [10:0] NUM_DEST_RESET = 11'd1;

   localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam int unsigned FMIX_SHIFT = 33;
   localparam logic [4:0]  MAX_OPEN_LEN = 5'd31;
   localparam logic [5:0]  CHUNK_SPAN = 6'd32;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0] code;
      logic       end_of_read;
   } dsb_entry_type;

   typedef struct packed {
      logic [63:0] supermer_bases;
      logic [4:0]  supermer_length;
      logic [59:0] minimizer_value;
      logic [9:0]  owner;
      logic        last_of_run;
   } dsb_result_type;

   typedef struct packed {
      logic        start;
      logic [59:0] minimizer;
   } dsb_hash_req_type;

   typedef struct packed {
      logic       done;
      logic [9:0] owner;
   } dsb_hash_rsp_type;

endpackage

@@ rtl/core/dsb_req_if.sv @@
// Input channel of the supermer builder: one base character per transfer.
// Depends on nothing.
interface dsb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] base;
   logic       end_of_read;

   modport source (output valid, base, end_of_read, input ready);
   modport sink (input valid, base, end_of_read, output ready);
endinterface

@@ rtl/core/dsb_rsp_if.sv @@
// Result channel of the supermer builder: one closed supermer per transfer.
// Depends on nothing.
interface dsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] supermer_bases;
   logic [4:0]  supermer_length;
   logic [59:0] minimizer_value;
   logic [9:0]  owner;
   logic        last_of_run;

   modport source (output valid, supermer_bases, supermer_length, minimizer_value, owner,
                   last_of_run, input ready);
   modport sink (input valid, supermer_bases, supermer_length, minimizer_value, owner,
                 last_of_run, output ready);
endinterface

@@ rtl/core/dsb_csr_if.sv @@
// Configuration write channel of the supermer builder.
// Depends on nothing.
interface dsb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/dsb_front.sv @@
// Front part: takes base characters, turns them into 2-bit codes and queues them.
// Depends on dsb_pkg.
module dsb_front
   import dsb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_base,
   input  logic          in_end_of_read,
   output logic          q_valid,
   output dsb_entry_type q_entry,
   input  logic          q_pop
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   dsb_entry_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]          fill_ff, fill_in;
   dsb_entry_type          classified;
   logic                   push;
   logic                   pop;

   assign classified.code        = {in_base[2], in_base[2] ^ in_base[1]};
   assign classified.end_of_read = in_end_of_read;

   assign in_ready = fill_ff != CW'(QUEUE_DEPTH);
   assign push     = in_valid && in_ready;
   assign q_valid  = fill_ff != '0;
   assign pop      = q_pop && q_valid;
   assign q_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

@@ rtl/core/dsb_owner.sv @@
// Owner unit: murmur3 64-bit finalizer and scaling by the destination count,
// done step by step on one shared 32 by 32 multiplier. Depends on dsb_pkg.
module dsb_owner
   import dsb_pkg::*;
#(
   parameter int unsigned MAX_DESTINATIONS = 1024
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [10:0]      num_destinations,
   input  dsb_hash_req_type hash_req,
   output dsb_hash_rsp_type hash_rsp
);

   localparam logic [3:0] LAST_STEP = 4'd13;

   logic        busy_ff, busy_in;
   logic [3:0]  step_ff, step_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [31:0] dest;
   logic [63:0] seed;

   assign dest = (32'(num_destinations) > 32'(MAX_DESTINATIONS)) ?
                 32'(MAX_DESTINATIONS) : 32'(num_destinations);
   assign seed = {4'b0, hash_req.minimizer};

   always_comb begin
      unique case (step_ff)
         4'd0:    begin op_a = h_ff[31:0];  op_b = FMIX_C1[31:0];  end
         4'd1:    begin op_a = h_ff[31:0];  op_b = FMIX_C1[63:32]; end
         4'd2:    begin op_a = h_ff[63:32]; op_b = FMIX_C1[31:0];  end
         4'd5:    begin op_a = h_ff[31:0];  op_b = FMIX_C2[31:0];  end
         4'd6:    begin op_a = h_ff[31:0];  op_b = FMIX_C2[63:32]; end
         4'd7:    begin op_a = h_ff[63:32]; op_b = FMIX_C2[31:0];  end
         4'd10:   begin op_a = h_ff[63:32]; op_b = dest;           end
         4'd11:   begin op_a = h_ff[31:0];  op_b = dest;           end
         default: begin op_a = '0;          op_b = '0;             end
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      h_in    = h_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (hash_req.start) begin
         h_in    = seed ^ (seed >> FMIX_SHIFT);
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         unique case (step_ff)
            4'd1, 4'd6, 4'd11:       acc_in = prod_ff;
            4'd2, 4'd3, 4'd7, 4'd8:  acc_in = acc_ff + {prod_ff[31:0], 32'b0};
            4'd12:                   acc_in = acc_ff + {32'b0, prod_ff[63:32]};
            4'd4, 4'd9:              h_in = acc_ff ^ (acc_ff >> FMIX_SHIFT);
            LAST_STEP:               busy_in = 1'b0;
            default:                 acc_in = acc_ff;
         endcase
      end
   end

   assign hash_rsp.done  = busy_ff && step_ff == LAST_STEP;
   assign hash_rsp.owner = acc_ff[41:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      prod_ff <= op_a * op_b;
   end

endmodule

@@ rtl/core/dsb_back.sv @@
// Back part: keeps the read state, finds each k-mer's minimizer one position a cycle,
// groups k-mers into supermers and drives the result register. Depends on dsb_pkg.
module dsb_back
   import dsb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [4:0]       k_len,
   input  logic [4:0]       m_len,
   input  logic             q_valid,
   input  dsb_entry_type    q_entry,
   output logic             q_pop,
   output dsb_hash_req_type hash_req,
   input  dsb_hash_rsp_type hash_rsp,
   output logic             out_valid,
   input  logic             out_ready,
   output dsb_result_type   out_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MIN    = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_HASH   = 3'd3;
   localparam logic [2:0] ST_TAIL   = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [61:0]    recent_ff, recent_in;
   logic [5:0]     count_ff, count_in;
   logic [4:0]     kic_ff, kic_in;
   logic [63:0]    open_sup_ff, open_sup_in;
   logic [4:0]     open_len_ff, open_len_in;
   logic [59:0]    prev_min_ff, prev_min_in;
   logic [9:0]     open_owner_ff, open_owner_in;
   logic [1:0]     code_ff, code_in;
   logic           eor_ff, eor_in;
   logic [63:0]    win_ff, win_in;
   logic [63:0]    kmer_ff, kmer_in;
   logic [4:0]     steps_ff, steps_in;
   logic [59:0]    best_ff, best_in;
   logic           out_valid_ff, out_valid_in;
   dsb_result_type out_data_ff, out_data_in;

   logic [4:0]  k_use;
   logic [4:0]  m_low;
   logic [4:0]  m_use;
   logic [61:0] recent_next;
   logic [5:0]  count_next;
   logic [63:0] aligned;
   logic [59:0] mmer;
   logic        out_free;
   logic [5:0]  kic_next;
   logic        first;
   logic        chunk;
   logic        start;
   logic        second;
   logic        tail_emit;
   logic [63:0] appended;

   assign k_use = (k_len < 5'd2) ? 5'd2 : k_len;
   assign m_low = (m_len == 5'd0) ? 5'd1 : m_len;
   assign m_use = (m_low > k_use) ? k_use : m_low;

   assign recent_next = {recent_ff[59:0], q_entry.code};
   assign count_next  = (count_ff == 6'd63) ? count_ff : count_ff + 6'd1;
   assign aligned     = {2'b00, recent_next} << (7'd64 - {1'b0, k_use, 1'b0});
   assign mmer        = 60'(win_ff >> (7'd64 - {1'b0, m_use, 1'b0}));
   assign out_free    = !out_valid_ff || out_ready;

   assign first     = open_len_ff == '0;
   assign kic_next  = {1'b0, kic_ff} + 6'd1;
   assign chunk     = kic_next >= (CHUNK_SPAN - {1'b0, k_use});
   assign start     = first || chunk || best_ff != prev_min_ff || open_len_ff >= MAX_OPEN_LEN;
   assign second    = eor_ff && count_ff > {1'b0, k_use};
   assign tail_emit = eor_ff && open_len_ff != '0 && count_ff > {1'b0, k_use};
   assign appended  = open_sup_ff | ({62'b0, code_ff} << (6'd62 - {open_len_ff, 1'b0}));

   always_comb begin
      state_in      = state_ff;
      recent_in     = recent_ff;
      count_in      = count_ff;
      kic_in        = kic_ff;
      open_sup_in   = open_sup_ff;
      open_len_in   = open_len_ff;
      prev_min_in   = prev_min_ff;
      open_owner_in = open_owner_ff;
      code_in       = code_ff;
      eor_in        = eor_ff;
      win_in        = win_ff;
      kmer_in       = kmer_ff;
      steps_in      = steps_ff;
      best_in       = best_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_data_in   = out_data_ff;
      q_pop         = 1'b0;
      hash_req.start     = 1'b0;
      hash_req.minimizer = best_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               recent_in = recent_next;
               count_in  = count_next;
               code_in   = q_entry.code;
               eor_in    = q_entry.end_of_read;
               win_in    = aligned;
               kmer_in   = aligned;
               steps_in  = k_use - m_use;
               best_in   = '1;
               state_in  = (count_next >= {1'b0, k_use}) ? ST_MIN : ST_TAIL;
            end
         end
         ST_MIN: begin
            if (mmer < best_ff) begin
               best_in = mmer;
            end
            win_in = {win_ff[61:0], 2'b00};
            if (steps_ff == '0) begin
               state_in = ST_DECIDE;
            end else begin
               steps_in = steps_ff - 5'd1;
            end
         end
         ST_DECIDE: begin
            if (!(start && !first) || out_free) begin
               kic_in = (first || chunk) ? 5'd0 : kic_next[4:0];
               if (start && !first) begin
                  out_valid_in                = 1'b1;
                  out_data_in.supermer_bases  = open_sup_ff;
                  out_data_in.supermer_length = open_len_ff;
                  out_data_in.minimizer_value = prev_min_ff;
                  out_data_in.owner           = open_owner_ff;
                  out_data_in.last_of_run     = !second;
               end
               if (start) begin
                  hash_req.start = 1'b1;
                  state_in       = ST_HASH;
               end else begin
                  open_sup_in = appended;
                  open_len_in = open_len_ff + 5'd1;
                  state_in    = ST_TAIL;
               end
            end
         end
         ST_HASH: begin
            if (hash_rsp.done) begin
               open_sup_in   = kmer_ff;
               open_len_in   = k_use;
               prev_min_in   = best_ff;
               open_owner_in = hash_rsp.owner;
               state_in      = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (!tail_emit || out_free) begin
               if (tail_emit) begin
                  out_valid_in                = 1'b1;
                  out_data_in.supermer_bases  = open_sup_ff;
                  out_data_in.supermer_length = open_len_ff;
                  out_data_in.minimizer_value = prev_min_ff;
                  out_data_in.owner           = open_owner_ff;
                  out_data_in.last_of_run     = 1'b1;
               end
               if (eor_ff) begin
                  recent_in     = '0;
                  count_in      = '0;
                  kic_in        = '0;
                  open_sup_in   = '0;
                  open_len_in   = '0;
                  prev_min_in   = '0;
                  open_owner_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         recent_ff     <= '0;
         count_ff      <= '0;
         kic_ff        <= '0;
         open_sup_ff   <= '0;
         open_len_ff   <= '0;
         prev_min_ff   <= '0;
         open_owner_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         recent_ff     <= recent_in;
         count_ff      <= count_in;
         kic_ff        <= kic_in;
         open_sup_ff   <= open_sup_in;
         open_len_ff   <= open_len_in;
         prev_min_ff   <= prev_min_in;
         open_owner_ff <= open_owner_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      eor_ff      <= eor_in;
      win_ff      <= win_in;
      kmer_ff     <= kmer_in;
      steps_ff    <= steps_in;
      best_ff     <= best_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ rtl/core/dsb_supermer_top_unused_guard.sv @@
// Configuration registers of the supermer builder, written through the write channel.
// Depends on dsb_pkg.
module dsb_csr
   import dsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   input  logic [1:0]  wr_index,
   input  logic [10:0] wr_data,
   output logic [4:0]  k_len,
   output logic [4:0]  m_len,
   output logic [10:0] num_destinations
);

   logic [4:0]  k_len_ff, k_len_in;
   logic [4:0]  m_len_ff, m_len_in;
   logic [10:0] dest_ff, dest_in;

   always_comb begin
      k_len_in = k_len_ff;
      m_len_in = m_len_ff;
      dest_in  = dest_ff;
      if (wr_valid) begin
         unique case (wr_index)
            REG_K_LEN:            k_len_in = wr_data[4:0];
            REG_M_LEN:            m_len_in = wr_data[4:0];
            REG_NUM_DESTINATIONS: dest_in  = wr_data;
            default:              dest_in  = dest_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_len_ff <= K_LEN_RESET;
         m_len_ff <= M_LEN_RESET;
         dest_ff  <= NUM_DEST_RESET;
      end else begin
         k_len_ff <= k_len_in;
         m_len_ff <= m_len_in;
         dest_ff  <= dest_in;
      end
   end

   assign k_len            = k_len_ff;
   assign m_len            = m_len_ff;
   assign num_destinations = dest_ff;

endmodule

@@ rtl/core/dna_supermer_builder.sv @@
// Minimizer supermer builder. One base character enters per transfer and is queued;
// the back part finishes each base before it takes the next. For a base that completes
// a k-mer it checks each minimizer position of the k-mer in turn on a single compare
// unit, and whenever a supermer opens it has the owner unit work out the owner on its
// shared 32 by 32 multiplier. Up to four bases queue ahead, and a result waits in the
// output register.
// Depends on dsb_pkg, the channel interfaces, dsb_csr, dsb_front, dsb_owner, dsb_back.
module dna_supermer_builder
   import dsb_pkg::*;
#(
   parameter int unsigned MAX_DESTINATIONS = 1024
)
(
   input  logic     clock,
   input  logic     reset,
   dsb_req_if.sink  req_chan,
   dsb_rsp_if.source rsp_chan,
   dsb_csr_if.sink  csr_chan
);

   logic [4:0]       k_len;
   logic [4:0]       m_len;
   logic [10:0]      num_destinations;
   logic             q_valid;
   dsb_entry_type    q_entry;
   logic             q_pop;
   dsb_hash_req_type hash_req;
   dsb_hash_rsp_type hash_rsp;
   dsb_result_type   out_data;

   assign csr_chan.ready = 1'b1;

   dsb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .wr_valid         (csr_chan.valid),
      .wr_index         (csr_chan.index),
      .wr_data          (csr_chan.data),
      .k_len            (k_len),
      .m_len            (m_len),
      .num_destinations (num_destinations)
   );

   dsb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .in_base        (req_chan.base),
      .in_end_of_read (req_chan.end_of_read),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   dsb_owner #(
      .MAX_DESTINATIONS (MAX_DESTINATIONS)
   ) u_owner (
      .clock            (clock),
      .reset            (reset),
      .num_destinations (num_destinations),
      .hash_req         (hash_req),
      .hash_rsp         (hash_rsp)
   );

   dsb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .k_len     (k_len),
      .m_len     (m_len),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .hash_req  (hash_req),
      .hash_rsp  (hash_rsp),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.supermer_bases  = out_data.supermer_bases;
   assign rsp_chan.supermer_length = out_data.supermer_length;
   assign rsp_chan.minimizer_value = out_data.minimizer_value;
   assign rsp_chan.owner           = out_data.owner;
   assign rsp_chan.last_of_run     = out_data.last_of_run;

endmodule

@@ bench/tb_checker.sv @@
// Checker of the supermer builder testbench: watches the three channels, predicts each
// closed supermer and compares it with what the block returns.
// Depends on dsb_pkg and the channel interfaces dsb_req_if, dsb_rsp_if and dsb_csr_if.
`timescale 1ns / 1ps

module tb_checker
   import dsb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dsb_req_if   req_mon,
   dsb_rsp_if   rsp_mon,
   dsb_csr_if   csr_mon,
   output int   fail_count,
   output int   pending,
   output int   supermers_seen
);

   localparam int unsigned DEST_LIMIT = 1024;

   logic [4:0]  k_cfg;
   logic [4:0]  m_cfg;
   logic [10:0] dest_cfg;

   logic [61:0] window_bases;
   int          bases_in_read;
   int          chunk_pos;
   logic [63:0] open_bases;
   int          open_len;
   logic [59:0] open_minimizer;
   logic [9:0]  open_owner;

   dsb_result_type supermer_queue[$];

   function automatic logic [1:0] code_of(logic [7:0] c);
      return {c[2], c[2] ^ c[1]};
   endfunction

   function automatic logic [63:0] fmix(logic [63:0] h);
      h = h ^ (h >> FMIX_SHIFT);
      h = h * FMIX_C1;
      h = h ^ (h >> FMIX_SHIFT);
      h = h * FMIX_C2;
      h = h ^ (h >> FMIX_SHIFT);
      return h;
   endfunction

   function automatic logic [9:0] owner_for(logic [59:0] mini);
      logic [127:0] product;
      logic [63:0]  n;
      n = (dest_cfg > DEST_LIMIT) ? 64'(DEST_LIMIT) : 64'(dest_cfg);
      product = 128'(fmix(64'(mini))) * 128'(n);
      return product[73:64];
   endfunction

   function automatic logic [59:0] least_mmer(logic [61:0] kmer, int k, int m);
      logic [63:0] mask;
      logic [63:0] best;
      logic [63:0] v;
      mask = (64'd1 << (2 * m)) - 64'd1;
      best = mask;
      for (int p = 0; p + m <= k; p++) begin
         v = (64'(kmer) >> (2 * (k - m - p))) & mask;
         if (v < best) best = v;
      end
      return best[59:0];
   endfunction

   function automatic dsb_result_type closed_supermer();
      dsb_result_type r;
      r.supermer_bases  = open_bases;
      r.supermer_length = 5'(open_len);
      r.minimizer_value = open_minimizer;
      r.owner           = open_owner;
      r.last_of_run     = 1'b0;
      return r;
   endfunction

   task automatic clear_read();
      window_bases   = '0;
      bases_in_read  = 0;
      chunk_pos      = 0;
      open_bases     = '0;
      open_len       = 0;
      open_minimizer = '0;
      open_owner     = '0;
   endtask

   task automatic predict_base(logic [7:0] base, logic eor);
      int             k;
      int             m;
      int             next;
      logic [1:0]     code;
      logic [61:0]    kmer;
      logic [59:0]    mini;
      logic           start;
      dsb_result_type made[$];
      k    = (k_cfg < 2) ? 2 : int'(k_cfg);
      m    = (m_cfg < 1) ? 1 : int'(m_cfg);
      if (m > k) m = k;
      code = code_of(base);
      window_bases = {window_bases[59:0], code};
      if (bases_in_read < 63) bases_in_read++;
      if (bases_in_read >= k) begin
         kmer  = window_bases & ((62'd1 << (2 * k)) - 62'd1);
         mini  = least_mmer(kmer, k, m);
         start = 1'b0;
         if (open_len == 0) begin
            chunk_pos = 0;
            start = 1'b1;
         end else begin
            next = chunk_pos + 1;
            if (next >= 32 - k) begin
               next = 0;
               start = 1'b1;
            end
            chunk_pos = next & 31;
            if (mini != open_minimizer || open_len >= 31) start = 1'b1;
            if (start) begin
               made = {made, closed_supermer()};
            end else begin
               open_bases = open_bases | (64'(code) << (62 - 2 * open_len));
               open_len++;
            end
         end
         if (start) begin
            open_bases     = 64'(kmer) << (64 - 2 * k);
            open_len       = k;
            open_minimizer = mini;
            open_owner     = owner_for(mini);
         end
      end
      if (eor) begin
         if (open_len != 0 && bases_in_read > k) made = {made, closed_supermer()};
         clear_read();
      end
      if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
      foreach (made[i]) supermer_queue = {supermer_queue, made[i]};
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      dsb_result_type want;
      if (reset) begin
         k_cfg    = K_LEN_RESET;
         m_cfg    = M_LEN_RESET;
         dest_cfg = NUM_DEST_RESET;
         clear_read();
         supermer_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            supermers_seen++;
            if (supermer_queue.size() == 0) begin
               $display("%0t: unexpected supermer, expected none, actual %h",
                        $time, rsp_mon.supermer_bases);
               fail_count++;
            end else begin
               want = supermer_queue.pop_front();
               compare_field("supermer_bases", want.supermer_bases, rsp_mon.supermer_bases);
               compare_field("supermer_length", 64'(want.supermer_length),
                             64'(rsp_mon.supermer_length));
               compare_field("minimizer_value", 64'(want.minimizer_value),
                             64'(rsp_mon.minimizer_value));
               compare_field("owner", 64'(want.owner), 64'(rsp_mon.owner));
               compare_field("last_of_run", 64'(want.last_of_run), 64'(rsp_mon.last_of_run));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_K_LEN: k_cfg = csr_mon.data[4:0];
               REG_M_LEN: m_cfg = csr_mon.data[4:0];
               REG_NUM_DESTINATIONS: dest_cfg = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) predict_base(req_mon.base, req_mon.end_of_read);
      end
      pending <= supermer_queue.size();
   end

   initial begin
      fail_count     = 0;
      pending        = 0;
      supermers_seen = 0;
   end

endmodule

@@ bench/tb_top.sv @@
// Top of the supermer builder testbench: clock, reset, reads of bases and register
// settings as stimulus, and the verdict. Depends on dsb_pkg, the channel interfaces,
// dna_supermer_builder and tb_checker.
`timescale 1ns / 1ps

module tb_top;
   import dsb_pkg::*;

   localparam int unsigned IDLE_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES = 400;
   localparam int unsigned HOLD_CYCLES = 1500;
   localparam int unsigned PHASE_ITEMS = 60;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   supermers_seen;
   int   items_sent;
   int   reads_sent;
   int   idle_cycles;
   int   burst_left;
   bit   gaps_on;
   bit   hold_request;
   bit   hold_done;

   dsb_req_if req_chan ();
   dsb_rsp_if rsp_chan ();
   dsb_csr_if csr_chan ();

   dna_supermer_builder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tb_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .fail_count     (fail_count),
      .pending        (pending),
      .supermers_seen (supermers_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // The receiver steps in turn through three stall patterns (always ready, random and a
   // fixed repeating pattern), and once holds off for a long stretch so that the block backs up onto its input.
   initial begin
      int tick;
      tick = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            case ((tick / 256) % 3)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= ((tick % 7) < 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_base(logic [7:0] base, logic eor);
      req_chan.valid       <= 1'b1;
      req_chan.base        <= base;
      req_chan.end_of_read <= eor;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (eor) reads_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (gaps_on) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [7:0] pick_base();
      string letters;
      letters = "ACGT";
      if ($urandom_range(0, 99) < 85) return letters[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_read(int len, bit closed);
      for (int i = 0; i < len; i++) send_base(pick_base(), closed && (i == len - 1));
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [10:0] k, logic [10:0] m, logic [10:0] n);
      logic [1:0]  idx[3];
      logic [10:0] val[3];
      idx = '{REG_K_LEN, REG_M_LEN, REG_NUM_DESTINATIONS};
      val = '{k, m, n};
      for (int i = 0; i < 3; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx[i];
         csr_chan.data  <= val[i];
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      logic [10:0] k_set[8];
      logic [10:0] m_set[8];
      logic [10:0] n_set[8];
      int          budget;
      int          len;
      k_set = '{20, 2, 31, 31, 0, 3, 8, 5};
      m_set = '{10, 1, 30, 1, 0, 31, 4, 5};
      n_set = '{1024, 1, 1024, 2047, 0, 5, 1000, 3};
      items_sent           = 0;
      reads_sent           = 0;
      idle_cycles          = 0;
      burst_left           = 0;
      gaps_on              = 1'b0;
      hold_request         = 1'b0;
      hold_done            = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.base        = '0;
      req_chan.end_of_read = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = '0;
      csr_chan.data        = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed reads: a read of exactly k bases, one just longer, extreme byte values
      // and a one-base read.
      write_settings(4, 2, 1024);
      send_base("A", 1'b0); send_base("C", 1'b0); send_base("G", 1'b0); send_base("T", 1'b1);
      send_base("T", 1'b0); send_base("G", 1'b0); send_base("C", 1'b0);
      send_base("A", 1'b0); send_base("A", 1'b1);
      send_base(8'h00, 1'b0); send_base(8'hff, 1'b0);
      for (int i = 0; i < 9; i++) send_base(pick_base(), 1'b0);
      send_base(8'hff, 1'b1);
      send_base("G", 1'b1);
      req_chan.valid <= 1'b0;

      // Random reads over a range of settings. A phase whose budget runs out part way through
      // a read stops there, so the next setting can take over an open supermer.
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_settings(k_set[p], m_set[p], n_set[p]);
         gaps_on = p[0];
         if (p == 3) hold_request = 1'b1;
         budget = PHASE_ITEMS;
         while (budget > 0) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 6);
            else len = int'(k_set[p][4:0]) + $urandom_range(0, 45);
            if (len > budget) begin
               send_read(budget, 1'b0);
               budget = 0;
            end else begin
               send_read(len, 1'b1);
               budget -= len;
            end
         end
         req_chan.valid <= 1'b0;
      end

      wait_idle();
      $display("Sent %0d bases in %0d complete reads over nine register settings.",
               items_sent, reads_sent);
      $display("Checked %0d supermers, with input gaps, output stalls and one long hold-off.",
               supermers_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/dsb_pkg.sv
rtl/core/dsb_req_if.sv
rtl/core/dsb_rsp_if.sv
rtl/core/dsb_csr_if.sv
rtl/core/dsb_front.sv
rtl/core/dsb_owner.sv
rtl/core/dsb_back.sv
rtl/core/dsb_supermer_top_unused_guard.sv
rtl/core/dna_supermer_builder.sv
bench/tb_checker.sv
bench/tb_top.sv
